>>> rtl/mfrf_pkg.sv
package mfrf_pkg;

   localparam int DISPLAY_WIDTH  = 200;
   localparam int DISPLAY_HEIGHT = 200;
   localparam int FRAME_BYTES    = (DISPLAY_WIDTH * DISPLAY_HEIGHT) / 8;

   localparam int MEM_AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int COL_W  = $clog2(DISPLAY_WIDTH + 1);
   localparam int ROW_W  = $clog2(DISPLAY_HEIGHT + 1);
   localparam int CB_W   = COL_W - 3;
   localparam int PIX_W  = $clog2(DISPLAY_WIDTH * DISPLAY_HEIGHT) + 1;
   localparam int SUM_W  = PIX_W;

   localparam logic [7:0] WHITE_BYTE = 8'hFF;
   localparam logic [2:0] BIT_MSB    = 3'd7;

   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_FILL  = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   typedef struct packed {
      logic signed [9:0] x;
      logic signed [9:0] y;
      logic [8:0]        width;
      logic [8:0]        height;
   } rect_type;

   typedef struct packed {
      logic              valid;
      logic [MEM_AW-1:0] addr;
      logic [7:0]        mask;
   } walk_op_type;

   typedef struct packed {
      logic              en;
      logic [MEM_AW-1:0] addr;
   } mem_rd_type;

   typedef struct packed {
      logic              en;
      logic [MEM_AW-1:0] addr;
      logic [7:0]        data;
   } mem_wr_type;

endpackage

>>> rtl/mfrf_ifs.sv
interface mfrf_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        func;
   logic signed [9:0] rect_x;
   logic signed [9:0] rect_y;
   logic [8:0]        rect_width;
   logic [8:0]        rect_height;
   logic              fill_black;
   logic [12:0]       byte_address;

   modport source (output valid, func, rect_x, rect_y, rect_width, rect_height,
                   fill_black, byte_address, input ready);
   modport sink   (input valid, func, rect_x, rect_y, rect_width, rect_height,
                   fill_black, byte_address, output ready);
endinterface

interface mfrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       address_ok;

   modport source (output valid, read_data, address_ok, input ready);
   modport sink   (input valid, read_data, address_ok, output ready);
endinterface

>>> rtl/mfrf_store.sv
module mfrf_store (
   input  logic                 clock,
   input  mfrf_pkg::mem_rd_type rd,
   input  mfrf_pkg::mem_wr_type wr,
   output logic [7:0]           rd_data
);

   logic [7:0] frame_mem [mfrf_pkg::FRAME_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         frame_mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= frame_mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/mfrf_walker.sv
module mfrf_walker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  mfrf_pkg::rect_type    rect,
   output mfrf_pkg::walk_op_type op,
   output logic                  busy
);

   localparam int COL_W = mfrf_pkg::COL_W;
   localparam int ROW_W = mfrf_pkg::ROW_W;
   localparam int CB_W  = mfrf_pkg::CB_W;
   localparam int PIX_W = mfrf_pkg::PIX_W;
   localparam int SUM_W = mfrf_pkg::SUM_W;

   localparam logic signed [10:0] WIDTH_S  = 11'(mfrf_pkg::DISPLAY_WIDTH);
   localparam logic signed [10:0] HEIGHT_S = 11'(mfrf_pkg::DISPLAY_HEIGHT);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_BASE = 2'd1;
   localparam logic [1:0] PH_RUN  = 2'd2;

   logic [1:0]       ph_ff, ph_in;
   logic [COL_W-1:0] x0_ff, x0_in;
   logic [COL_W-1:0] xl_ff, xl_in;
   logic [ROW_W-1:0] y_ff, y_in;
   logic [ROW_W-1:0] yl_ff, yl_in;
   logic [CB_W-1:0]  col_ff, col_in;
   logic [PIX_W-1:0] row_pix_ff, row_pix_in;

   logic signed [10:0] x_end, y_end, x_lo, y_lo, x_hi, y_hi, x_last, y_last;
   logic               empty;
   logic [CB_W-1:0]    col_first, col_last;
   logic [SUM_W-1:0]   byte_sum;
   logic [7:0]         lo_mask, hi_mask;

   always_comb begin
      x_end  = $signed({rect.x[9], rect.x}) + $signed({2'b00, rect.width});
      y_end  = $signed({rect.y[9], rect.y}) + $signed({2'b00, rect.height});
      x_lo   = rect.x[9] ? 11'sd0 : $signed({rect.x[9], rect.x});
      y_lo   = rect.y[9] ? 11'sd0 : $signed({rect.y[9], rect.y});
      x_hi   = (x_end > WIDTH_S) ? WIDTH_S : x_end;
      y_hi   = (y_end > HEIGHT_S) ? HEIGHT_S : y_end;
      x_last = x_hi - 11'sd1;
      y_last = y_hi - 11'sd1;
      empty  = (x_hi <= x_lo) || (y_hi <= y_lo);
   end

   assign col_first = x0_ff[COL_W-1:3];
   assign col_last  = xl_ff[COL_W-1:3];
   assign byte_sum  = SUM_W'(row_pix_ff[PIX_W-1:3]) + SUM_W'(col_ff);
   assign lo_mask   = (col_ff == col_first) ? (8'hFF >> x0_ff[2:0]) : 8'hFF;
   assign hi_mask   = (col_ff == col_last)
                      ? 8'(8'hFF << (mfrf_pkg::BIT_MSB - xl_ff[2:0])) : 8'hFF;

   always_comb begin
      op.valid = (ph_ff == PH_RUN) && (byte_sum < SUM_W'(mfrf_pkg::FRAME_BYTES));
      op.addr  = byte_sum[mfrf_pkg::MEM_AW-1:0];
      op.mask  = lo_mask & hi_mask;
   end

   assign busy = (ph_ff != PH_IDLE);

   always_comb begin
      ph_in      = ph_ff;
      x0_in      = x0_ff;
      xl_in      = xl_ff;
      y_in       = y_ff;
      yl_in      = yl_ff;
      col_in     = col_ff;
      row_pix_in = row_pix_ff;
      case (ph_ff)
         PH_IDLE: begin
            if (start) begin
               x0_in = x_lo[COL_W-1:0];
               xl_in = x_last[COL_W-1:0];
               y_in  = y_lo[ROW_W-1:0];
               yl_in = y_last[ROW_W-1:0];
               ph_in = empty ? PH_IDLE : PH_BASE;
            end
         end
         PH_BASE: begin
            row_pix_in = PIX_W'(y_ff * mfrf_pkg::DISPLAY_WIDTH);
            col_in     = col_first;
            ph_in      = PH_RUN;
         end
         PH_RUN: begin
            if (col_ff == col_last) begin
               if (y_ff == yl_ff) begin
                  ph_in = PH_IDLE;
               end else begin
                  y_in       = y_ff + ROW_W'(1);
                  row_pix_in = row_pix_ff + PIX_W'(mfrf_pkg::DISPLAY_WIDTH);
                  col_in     = col_first;
               end
            end else begin
               col_in = col_ff + CB_W'(1);
            end
         end
         default: begin
            ph_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE;
      end else begin
         ph_ff <= ph_in;
      end
      x0_ff      <= x0_in;
      xl_ff      <= xl_in;
      y_ff       <= y_in;
      yl_ff      <= yl_in;
      col_ff     <= col_in;
      row_pix_ff <= row_pix_in;
   end

endmodule

>>> rtl/mono_framebuffer_rect_fill_core.sv
// Channel  Dir  Handshake      Payload
// req_if   in   valid / ready  func, rect_x, rect_y, rect_width, rect_height,
//                              fill_black, byte_address
// rsp_if   out  valid / ready  read_data, address_ok
//
// One transaction in flight; a new one is taken while the previous response waits.
// Fill: one byte read-modify-write per cycle through the single frame memory.
// Clear: a sweep writes every byte of the frame white. Read: the byte comes from a registered memory read.
// After reset a clearing pass writes all FRAME_BYTES (5000) bytes white with req_if.ready low.
// A stalled response holds the block in its final state until the slot frees.
module mono_framebuffer_rect_fill_core (
   input logic        clock,
   input logic        reset,
   mfrf_req_if.sink   req_if,
   mfrf_rsp_if.source rsp_if
);

   localparam int MEM_AW = mfrf_pkg::MEM_AW;

   localparam logic [2:0] ST_SWEEP = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_FILL  = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [MEM_AW-1:0] sweep_ff, sweep_in;
   logic              sweep_req_ff, sweep_req_in;
   logic              black_ff, black_in;
   logic [7:0]        res_data_ff, res_data_in;
   logic              res_ok_ff, res_ok_in;
   logic              b_valid_ff, b_valid_in;
   logic [MEM_AW-1:0] b_addr_ff, b_addr_in;
   logic [7:0]        b_mask_ff, b_mask_in;
   logic              fwd_valid_ff, fwd_valid_in;
   logic [MEM_AW-1:0] fwd_addr_ff, fwd_addr_in;
   logic [7:0]        fwd_data_ff, fwd_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              rsp_ok_ff, rsp_ok_in;

   logic                  req_accept;
   logic                  addr_in_frame;
   logic                  walk_start;
   logic                  walk_busy;
   mfrf_pkg::rect_type    rect;
   mfrf_pkg::walk_op_type op;
   mfrf_pkg::mem_rd_type  rd;
   mfrf_pkg::mem_wr_type  wr;
   logic [7:0]            rd_data;
   logic [7:0]            old_byte;
   logic [7:0]            new_byte;
   logic                  sweeping;
   logic                  rsp_load;

   assign req_if.ready  = (state_ff == ST_IDLE);
   assign req_accept    = req_if.valid && req_if.ready;
   assign addr_in_frame = 32'(req_if.byte_address) < 32'(mfrf_pkg::FRAME_BYTES);
   assign walk_start    = req_accept && (req_if.func == mfrf_pkg::FUNC_FILL);

   always_comb begin
      rect.x      = req_if.rect_x;
      rect.y      = req_if.rect_y;
      rect.width  = req_if.rect_width;
      rect.height = req_if.rect_height;
   end

   mfrf_walker u_walker (
      .clock (clock),
      .reset (reset),
      .start (walk_start),
      .rect  (rect),
      .op    (op),
      .busy  (walk_busy)
   );

   assign sweeping = (state_ff == ST_SWEEP);
   assign old_byte = (fwd_valid_ff && (fwd_addr_ff == b_addr_ff)) ? fwd_data_ff : rd_data;
   assign new_byte = black_ff ? (old_byte & ~b_mask_ff) : (old_byte | b_mask_ff);

   always_comb begin
      rd.en   = op.valid || (req_accept && (req_if.func == mfrf_pkg::FUNC_READ)
                             && addr_in_frame);
      rd.addr = op.valid ? op.addr : MEM_AW'(req_if.byte_address);
      wr.en   = sweeping || b_valid_ff;
      wr.addr = sweeping ? sweep_ff : b_addr_ff;
      wr.data = sweeping ? mfrf_pkg::WHITE_BYTE : new_byte;
   end

   mfrf_store u_store (
      .clock   (clock),
      .rd      (rd),
      .wr      (wr),
      .rd_data (rd_data)
   );

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      sweep_req_in = sweep_req_ff;
      black_in     = black_ff;
      res_data_in  = res_data_ff;
      res_ok_in    = res_ok_ff;
      b_valid_in   = op.valid;
      b_addr_in    = op.addr;
      b_mask_in    = op.mask;
      fwd_valid_in = b_valid_ff;
      fwd_addr_in  = b_addr_ff;
      fwd_data_in  = new_byte;
      case (state_ff)
         ST_SWEEP: begin
            sweep_in = sweep_ff + MEM_AW'(1);
            if (sweep_ff == MEM_AW'(mfrf_pkg::FRAME_BYTES - 1)) begin
               state_in = sweep_req_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               res_data_in = 8'h00;
               res_ok_in   = 1'b1;
               black_in    = req_if.fill_black;
               case (req_if.func)
                  mfrf_pkg::FUNC_CLEAR: begin
                     sweep_in     = '0;
                     sweep_req_in = 1'b1;
                     state_in     = ST_SWEEP;
                  end
                  mfrf_pkg::FUNC_FILL: begin
                     state_in = ST_FILL;
                  end
                  mfrf_pkg::FUNC_READ: begin
                     res_ok_in = addr_in_frame;
                     state_in  = ST_READ;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_FILL: begin
            if (!walk_busy && !b_valid_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            res_data_in = res_ok_ff ? rd_data : 8'h00;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data_ff;
         rsp_ok_in    = res_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         sweep_req_ff <= 1'b0;
         b_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         sweep_req_ff <= sweep_req_in;
         b_valid_ff   <= b_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      black_ff    <= black_in;
      res_data_ff <= res_data_in;
      res_ok_ff   <= res_ok_in;
      b_addr_ff   <= b_addr_in;
      b_mask_ff   <= b_mask_in;
      fwd_addr_ff <= fwd_addr_in;
      fwd_data_ff <= fwd_data_in;
      rsp_data_ff <= rsp_data_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.read_data  = rsp_data_ff;
   assign rsp_if.address_ok = rsp_ok_ff;

`ifndef SYNTH
   a_rmw_only_in_fill: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (state_ff == ST_FILL))
      else $error("byte write-back outside a fill");

   a_walker_only_in_fill: assert property (@(posedge clock) disable iff (reset)
      walk_busy |-> (state_ff == ST_FILL))
      else $error("rectangle walker active outside a fill");

   a_no_read_in_sweep: assert property (@(posedge clock) disable iff (reset)
      sweeping |-> !rd.en)
      else $error("frame read during clearing pass");

   a_read_follows: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_if.func == mfrf_pkg::FUNC_READ)) |=> (state_ff == ST_READ))
      else $error("read transaction did not enter read state");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised without a finished transaction");
`endif

endmodule
